// ===== hdl/button_debounce_report_scheduler_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BUTTON_DEBOUNCE_REPORT_SCHEDULER_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_REPORT_SCHEDULER_TOP_ASSERT_SVH

// Checked at every rising clock edge, switched off while reset is held.
`define BDRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define BDRS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bdrs_pkg.sv =====
package bdrs_pkg;

    // Lane count and the number of buttons that a report carries.
    localparam int DEF_NUM_BUTTONS = 5;
    localparam int REPORT_BUTTONS  = 5;

    // Field widths.
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int PRESS_W    = 32;
    localparam int SEQ_W      = 32;
    localparam int MS_CFG_W   = 16;
    localparam int REPEAT_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [MS_CFG_W-1:0] DEBOUNCE_RST     = 16'd15;
    localparam logic [MS_CFG_W-1:0] MIN_INTERVAL_RST = 16'd20;
    localparam logic [MS_CFG_W-1:0] HEARTBEAT_RST    = 16'd1000;
    localparam logic [REPEAT_W-1:0] REPEAT_RST       = 4'd3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_MIN_INTERVAL = 2'd1,
        CFG_HEARTBEAT    = 2'd2,
        CFG_REPEAT       = 2'd3
    } t_cfg_idx;

    // Configuration as seen by the lanes and the scheduler.
    typedef struct packed {
        logic [MS_CFG_W-1:0] debounce_ms;
        logic [MS_CFG_W-1:0] min_interval_ms;
        logic [MS_CFG_W-1:0] beat_period_ms;
        logic [REPEAT_W-1:0] repeat_count;
    } t_cfg;

endpackage

// ===== hdl/bdrs_if.sv =====
// Scan pass channel.
interface bdrs_in_if import bdrs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [TIME_W-1:0]          now_ms;
    logic [REPORT_BUTTONS-1:0]  raw_buttons;
    logic signed [COUNT_W-1:0]  enc_count;

    modport source (output valid, now_ms, raw_buttons, enc_count, input ready);
    modport sink   (input valid, now_ms, raw_buttons, enc_count, output ready);
endinterface

// Report channel.
interface bdrs_out_if import bdrs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       send;
    logic [REPORT_BUTTONS-1:0]  button_mask;
    logic signed [COUNT_W-1:0]  report_count;
    logic [SEQ_W-1:0]           sequence_res;
    logic [TIME_W-1:0]          uptime_ms;
    logic [PRESS_W-1:0]         presses_0;
    logic [PRESS_W-1:0]         presses_1;
    logic [PRESS_W-1:0]         presses_2;
    logic [PRESS_W-1:0]         presses_3;
    logic [PRESS_W-1:0]         presses_4;

    modport source (output valid, send, button_mask, report_count, sequence_res,
                    uptime_ms, presses_0, presses_1, presses_2, presses_3,
                    presses_4, input ready);
    modport sink   (input valid, send, button_mask, report_count, sequence_res,
                    uptime_ms, presses_0, presses_1, presses_2, presses_3,
                    presses_4, output ready);
endinterface

// Configuration write channel.
interface bdrs_cfg_if import bdrs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bdrs_lane.sv =====
module bdrs_lane import bdrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [TIME_W-1:0]   i_now,
    input  logic                i_raw,
    input  logic [MS_CFG_W-1:0] i_debounce_ms,
    output logic                o_pressed,
    output logic [PRESS_W-1:0]  o_presses
);

    logic               r_stable;
    logic               r_last_raw;
    logic [TIME_W-1:0]  r_edge_time;
    logic [PRESS_W-1:0] r_presses;

    logic               n_stable;
    logic               n_last_raw;
    logic [TIME_W-1:0]  n_edge_time;
    logic [PRESS_W-1:0] n_presses;

    logic               raw_edge;
    logic [TIME_W-1:0]  quiet_time;
    logic               settle;

    // A raw edge restarts the quiet time, so a level is taken only on a pass without one.
    assign raw_edge   = (i_raw != r_last_raw);
    assign quiet_time = i_now - r_edge_time;
    assign settle     = !raw_edge
                        && (quiet_time > {{(TIME_W-MS_CFG_W){1'b0}}, i_debounce_ms})
                        && (i_raw != r_stable);

    // Next lane state for an accepted scan pass.
    always_comb begin
        n_stable    = r_stable;
        n_last_raw  = r_last_raw;
        n_edge_time = r_edge_time;
        n_presses   = r_presses;
        if (i_accept) begin
            if (raw_edge) begin
                n_last_raw  = i_raw;
                n_edge_time = i_now;
            end
            if (settle) begin
                n_stable = i_raw;
                if (!i_raw) begin
                    n_presses = r_presses + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable    <= 1'b1;
            r_last_raw  <= 1'b1;
            r_edge_time <= '0;
            r_presses   <= '0;
        end else begin
            r_stable    <= n_stable;
            r_last_raw  <= n_last_raw;
            r_edge_time <= n_edge_time;
            r_presses   <= n_presses;
        end
    end

    // The lane state after the last pass is the stage output.
    assign o_pressed = !r_stable;
    assign o_presses = r_presses;

endmodule

// ===== hdl/bdrs_sched.sv =====
module bdrs_sched import bdrs_pkg::*; #(
    parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_valid,
    input  logic [TIME_W-1:0]         i_now,
    input  logic signed [COUNT_W-1:0] i_count,
    input  logic                      i_pressed [NUM_BUTTONS],
    input  logic [PRESS_W-1:0]        i_presses [NUM_BUTTONS],
    output logic                      o_take,
    bdrs_out_if.source                o_out
);

    logic [REPORT_BUTTONS-1:0] mask;
    logic [PRESS_W-1:0]        presses [REPORT_BUTTONS];

    // Merge the lanes: buttons beyond the lane count read as released.
    for (genvar b = 0; b < REPORT_BUTTONS; b++) begin : g_merge
        if (b < NUM_BUTTONS) begin : g_lane
            assign mask[b]    = i_pressed[b];
            assign presses[b] = i_presses[b];
        end else begin : g_none
            assign mask[b]    = 1'b0;
            assign presses[b] = '0;
        end
    end

    logic                      r_sent_valid;
    logic signed [COUNT_W-1:0] r_last_value;
    logic [REPORT_BUTTONS-1:0] r_last_buttons;
    logic [TIME_W-1:0]         r_last_send_time;
    logic [REPEAT_W-1:0]       r_repeats_left;
    logic [SEQ_W-1:0]          r_seq;
    logic                      r_out_valid;
    logic                      r_send;
    logic [REPORT_BUTTONS-1:0] r_mask;
    logic signed [COUNT_W-1:0] r_count;
    logic [TIME_W-1:0]         r_uptime;
    logic [PRESS_W-1:0]        r_presses [REPORT_BUTTONS];

    logic                change;
    logic [REPEAT_W-1:0] repeats;
    logic [TIME_W-1:0]   since_send;
    logic                due;
    logic                send;
    logic [REPEAT_W-1:0] n_repeats_left;

    // The output register takes a pass when it is empty or being emptied.
    assign o_take = i_valid && (!r_out_valid || o_out.ready);

    // Report decision: a change reloads the repeat budget, the heartbeat forces a report.
    assign change     = !r_sent_valid || (i_count != r_last_value) || (mask != r_last_buttons);
    assign repeats    = change ? i_cfg.repeat_count : r_repeats_left;
    assign since_send = i_now - r_last_send_time;
    assign due        = since_send >= {{(TIME_W-MS_CFG_W){1'b0}}, i_cfg.beat_period_ms};
    assign send       = ((repeats != '0)
                         && (since_send >= {{(TIME_W-MS_CFG_W){1'b0}}, i_cfg.min_interval_ms}))
                        || due;

    always_comb begin
        n_repeats_left = repeats;
        if (send && (repeats != '0)) begin
            n_repeats_left = repeats - 1'b1;
        end
    end

    // Scheduler state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_valid     <= 1'b0;
            r_last_value     <= '0;
            r_last_buttons   <= '0;
            r_last_send_time <= '0;
            r_repeats_left   <= '0;
            r_seq            <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (o_take) begin
                r_repeats_left <= n_repeats_left;
                if (send) begin
                    r_sent_valid     <= 1'b1;
                    r_last_value     <= i_count;
                    r_last_buttons   <= mask;
                    r_last_send_time <= i_now;
                    r_seq            <= r_seq + 1'b1;
                end
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Report payload.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_send   <= send;
            r_mask   <= mask;
            r_count  <= i_count;
            r_uptime <= i_now;
            r_presses <= presses;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.send         = r_send;
    assign o_out.button_mask  = r_mask;
    assign o_out.report_count = r_count;
    assign o_out.sequence_res = r_seq;
    assign o_out.uptime_ms    = r_uptime;
    assign o_out.presses_0    = r_presses[0];
    assign o_out.presses_1    = r_presses[1];
    assign o_out.presses_2    = r_presses[2];
    assign o_out.presses_3    = r_presses[3];
    assign o_out.presses_4    = r_presses[4];

endmodule

// ===== hdl/button_debounce_report_scheduler_top.sv =====
// A scan pass is registered in the lane stage and then in the scheduler's output
// register, and its report is offered from that output register.
// Throughput: one scan pass per cycle while reports are taken; the button
// lanes and the scheduler's 32-bit time compares each sit in a stage of their own.
// Reset (synchronous, active low) releases all buttons, clears counters and
// sequence, and loads the configuration defaults. Configuration is always ready.
module button_debounce_report_scheduler_top import bdrs_pkg::*; #(
    parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdrs_in_if.sink     i_in,
    bdrs_out_if.source  o_out,
    bdrs_cfg_if.sink    i_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Configuration registers.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_DEBOUNCE:     n_cfg.debounce_ms     = i_cfg.data[MS_CFG_W-1:0];
                CFG_MIN_INTERVAL: n_cfg.min_interval_ms = i_cfg.data[MS_CFG_W-1:0];
                CFG_HEARTBEAT:    n_cfg.beat_period_ms  = i_cfg.data[MS_CFG_W-1:0];
                CFG_REPEAT:       n_cfg.repeat_count    = i_cfg.data[REPEAT_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{debounce_ms:     DEBOUNCE_RST,
                       min_interval_ms: MIN_INTERVAL_RST,
                       beat_period_ms:  HEARTBEAT_RST,
                       repeat_count:    REPEAT_RST};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign i_cfg.ready = 1'b1;

    // Lane stage handshake: the lanes advance on each pass accepted at the input.
    logic                      r_s1_valid;
    logic [TIME_W-1:0]         r_s1_now;
    logic signed [COUNT_W-1:0] r_s1_count;
    logic                      take;
    logic                      accept;

    assign i_in.ready = !r_s1_valid || take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_now   <= i_in.now_ms;
            r_s1_count <= i_in.enc_count;
        end
    end

    // One debounce lane per button.
    logic               pressed [NUM_BUTTONS];
    logic [PRESS_W-1:0] presses [NUM_BUTTONS];

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic raw;
        if (g < REPORT_BUTTONS) begin : g_raw
            assign raw = i_in.raw_buttons[g];
        end else begin : g_tied
            assign raw = 1'b0;
        end

        bdrs_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_accept      (accept),
            .i_now         (i_in.now_ms),
            .i_raw         (raw),
            .i_debounce_ms (r_cfg.debounce_ms),
            .o_pressed     (pressed[g]),
            .o_presses     (presses[g])
        );
    end

    // Merge and report scheduling.
    bdrs_sched #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (r_s1_valid),
        .i_now     (r_s1_now),
        .i_count   (r_s1_count),
        .i_pressed (pressed),
        .i_presses (presses),
        .o_take    (take),
        .o_out     (o_out)
    );

endmodule

// ===== hdl/bdrs_checker.sv =====
`include "button_debounce_report_scheduler_top_assert.svh"

module bdrs_checker import bdrs_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_send,
    input logic [REPORT_BUTTONS-1:0] i_out_mask,
    input logic [COUNT_W-1:0]        i_out_count,
    input logic [SEQ_W-1:0]          i_out_seq,
    input logic [TIME_W-1:0]         i_out_uptime
);

    // Sequence number of the last report transaction.
    logic [SEQ_W-1:0] r_last_seq;
    logic             out_fire;

    assign out_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq <= '0;
        end else if (out_fire) begin
            r_last_seq <= i_out_seq;
        end
    end

    // A report pending at the port stays until it is taken.
    `BDRS_ASSERT(a_out_hold, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=> i_out_valid,
        "report withdrawn before transaction")

    // The sequence steps by one exactly on transactions that carry a report.
    `BDRS_ASSERT(a_seq_step, i_clk, i_rst_n,
        out_fire |-> (i_out_seq == r_last_seq + {{(SEQ_W-1){1'b0}}, i_out_send}),
        "sequence number does not follow the report flag")

    // Nothing is offered in the cycle after reset.
    `BDRS_ASSERT_ALWAYS(a_rst_empty, i_clk,
        !i_rst_n |=> !i_out_valid,
        "report offered right after reset")

    // A stalled report keeps its scheduling fields.
    `BDRS_ASSERT(a_out_stable, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_send) && $stable(i_out_seq)
            && $stable(i_out_mask) && $stable(i_out_count) && $stable(i_out_uptime)),
        "stalled report changed")

endmodule

bind button_debounce_report_scheduler_top bdrs_checker u_bdrs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_send   (o_out.send),
    .i_out_mask   (o_out.button_mask),
    .i_out_count  (o_out.report_count),
    .i_out_seq    (o_out.sequence_res),
    .i_out_uptime (o_out.uptime_ms)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bdrs_pkg::*;

    localparam int NUM_ROWS      = 30;
    localparam int DEFAULT_ROWS  = 23;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_STALL    = 400;
    localparam int LONG_STALL_AT = 700;

    // One scan pass of the directed table; chk marks a typed-in expectation.
    typedef struct packed {
        logic [TIME_W-1:0]         now;
        logic [REPORT_BUTTONS-1:0] raw;
        logic [COUNT_W-1:0]        cnt;
        logic                      chk;
        logic                      exp_send;
        logic [REPORT_BUTTONS-1:0] exp_mask;
        logic [SEQ_W-1:0]          exp_seq;
    } t_scan_row;

    // Everything one report carries.
    typedef struct packed {
        logic                                   send;
        logic [REPORT_BUTTONS-1:0]              mask;
        logic [COUNT_W-1:0]                     count;
        logic [SEQ_W-1:0]                       seq;
        logic [TIME_W-1:0]                      uptime;
        logic [REPORT_BUTTONS-1:0][PRESS_W-1:0] presses;
    } t_report;

    logic clk;
    logic rst_n;

    bdrs_in_if  scan_if ();
    bdrs_out_if rep_if ();
    bdrs_cfg_if cfg_if ();

    button_debounce_report_scheduler_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (scan_if),
        .o_out   (rep_if),
        .i_cfg   (cfg_if)
    );

    // Directed passes: defaults first, then the all-low setting.
    t_scan_row directed_rows [0:NUM_ROWS-1] = '{
        '{32'd0,    5'h1F, 32'd0,        1'b1, 1'b0, 5'h00, 32'd0},
        '{32'd10,   5'h1F, 32'd0,        1'b1, 1'b0, 5'h00, 32'd0},
        '{32'd20,   5'h1F, 32'd0,        1'b1, 1'b1, 5'h00, 32'd1},
        '{32'd25,   5'h1F, 32'd0,        1'b1, 1'b0, 5'h00, 32'd1},
        '{32'd40,   5'h1F, 32'd0,        1'b1, 1'b1, 5'h00, 32'd2},
        '{32'd60,   5'h1F, 32'd0,        1'b1, 1'b1, 5'h00, 32'd3},
        '{32'd100,  5'h1F, 32'd0,        1'b1, 1'b0, 5'h00, 32'd3},
        '{32'd110,  5'h1E, 32'd0,        1'b1, 1'b0, 5'h00, 32'd3},
        '{32'd120,  5'h1E, 32'd0,        1'b1, 1'b0, 5'h00, 32'd3},
        '{32'd126,  5'h1E, 32'd0,        1'b1, 1'b1, 5'h01, 32'd4},
        '{32'd130,  5'h1F, 32'd0,        1'b1, 1'b0, 5'h01, 32'd4},
        '{32'd132,  5'h1E, 32'd0,        1'b1, 1'b0, 5'h01, 32'd4},
        '{32'd150,  5'h1E, 32'd0,        1'b1, 1'b1, 5'h01, 32'd5},
        '{32'd200,  5'h00, 32'h7FFFFFFF, 1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd220,  5'h00, 32'h80000000, 1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd240,  5'h00, 32'hFFFFFFFF, 1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd1500, 5'h00, 32'hFFFFFFFF, 1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd3000, 5'h1F, 32'hFFFFFFFF, 1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd3100, 5'h1F, 32'd0,        1'b0, 1'b0, 5'h00, 32'd0},
        '{32'hFFFFFFF0, 5'h15, 32'd12345, 1'b0, 1'b0, 5'h00, 32'd0},
        '{32'hFFFFFFFF, 5'h0A, 32'd12345, 1'b0, 1'b0, 5'h00, 32'd0},
        '{32'h00000008, 5'h0A, 32'h80000000, 1'b0, 1'b0, 5'h00, 32'd0},
        '{32'h00000030, 5'h1F, 32'd0,    1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd5000, 5'h1F, 32'd1,        1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd5000, 5'h1E, 32'd1,        1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd5001, 5'h1E, 32'd1,        1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd5001, 5'h1F, 32'd2,        1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd5002, 5'h1F, 32'd2,        1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd5002, 5'h00, 32'hFFFFFFFF, 1'b0, 1'b0, 5'h00, 32'd0},
        '{32'd5003, 5'h00, 32'd0,        1'b0, 1'b0, 5'h00, 32'd0}
    };

    // Shadow state of the scheduler.
    t_cfg                                   sched_cfg;
    logic [REPORT_BUTTONS-1:0]              debounced;
    logic [REPORT_BUTTONS-1:0]              prev_raw;
    logic [REPORT_BUTTONS-1:0][TIME_W-1:0]  edge_stamp;
    logic [REPORT_BUTTONS-1:0][PRESS_W-1:0] press_cnt;
    logic [TIME_W-1:0]                      last_report_ms;
    logic [TIME_W-1:0]                      last_beat_ms;
    logic [COUNT_W-1:0]                     sent_count;
    logic [REPORT_BUTTONS-1:0]              sent_mask;
    logic                                   anything_sent;
    logic [REPEAT_W-1:0]                    repeats_pending;
    logic [SEQ_W-1:0]                       seq_num;

    t_report pending_reports [$];
    int      mismatches;
    int      reports_seen;
    int      scans_sent;
    logic    tx_burst;

    // Random scan generator state.
    logic [TIME_W-1:0]         stim_now;
    logic [REPORT_BUTTONS-1:0] stim_held;
    logic [COUNT_W-1:0]        stim_count;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Debounce every lane, track the repeat budget and decide on a report.
    task automatic predict_report(input logic [TIME_W-1:0] now,
                                  input logic [REPORT_BUTTONS-1:0] raw,
                                  input logic [COUNT_W-1:0] cnt,
                                  output t_report rep);
        logic [TIME_W-1:0]         quiet;
        logic [REPORT_BUTTONS-1:0] mask;
        logic                      due;
        logic                      fire;
        mask = '0;
        for (int b = 0; b < REPORT_BUTTONS; b++) begin
            if (raw[b] != prev_raw[b]) begin
                prev_raw[b]   = raw[b];
                edge_stamp[b] = now;
            end
            quiet = now - edge_stamp[b];
            if (quiet > {16'd0, sched_cfg.debounce_ms} && raw[b] != debounced[b]) begin
                debounced[b] = raw[b];
                if (!raw[b])
                    press_cnt[b] = press_cnt[b] + 32'd1;
            end
            mask[b] = !debounced[b];
        end

        // Any change since the last report reloads the repeat budget.
        if (!anything_sent || cnt != sent_count || mask != sent_mask)
            repeats_pending = sched_cfg.repeat_count;

        quiet = now - last_beat_ms;
        due   = quiet >= {16'd0, sched_cfg.beat_period_ms};
        quiet = now - last_report_ms;
        fire  = (repeats_pending != 0 && quiet >= {16'd0, sched_cfg.min_interval_ms}) || due;
        if (fire) begin
            if (repeats_pending != 0)
                repeats_pending = repeats_pending - 1'b1;
            sent_count     = cnt;
            sent_mask      = mask;
            anything_sent  = 1'b1;
            last_beat_ms   = now;
            last_report_ms = now;
            seq_num        = seq_num + 32'd1;
        end

        rep.send    = fire;
        rep.mask    = mask;
        rep.count   = cnt;
        rep.seq     = seq_num;
        rep.uptime  = now;
        rep.presses = press_cnt;
    endtask

    // Offer one scan pass and record its expected report once it is taken.
    task automatic drive_scan(input t_scan_row row);
        int      gap;
        t_report rep;
        if (scans_sent % 50 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge clk);
            scan_if.valid <= 1'b0;
        end
        @(negedge clk);
        scan_if.valid       <= 1'b1;
        scan_if.now_ms      <= row.now;
        scan_if.raw_buttons <= row.raw;
        scan_if.enc_count   <= row.cnt;
        do @(posedge clk); while (!scan_if.ready);
        predict_report(row.now, row.raw, row.cnt, rep);
        if (row.chk) begin
            rep.send = row.exp_send;
            rep.mask = row.exp_mask;
            rep.seq  = row.exp_seq;
        end
        pending_reports.push_back(rep);
        scans_sent++;
    endtask

    task automatic end_scans();
        @(negedge clk);
        scan_if.valid <= 1'b0;
    endtask

    // Let every outstanding report come out before touching the registers.
    task automatic drain_reports();
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            CFG_DEBOUNCE:     sched_cfg.debounce_ms     = value;
            CFG_MIN_INTERVAL: sched_cfg.min_interval_ms = value;
            CFG_HEARTBEAT:    sched_cfg.beat_period_ms  = value;
            CFG_REPEAT:       sched_cfg.repeat_count    = value[REPEAT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] deb,
                                 input logic [CFG_DATA_W-1:0] gap_ms,
                                 input logic [CFG_DATA_W-1:0] beat_ms,
                                 input logic [CFG_DATA_W-1:0] repeats);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_MIN_INTERVAL, gap_ms);
        write_reg(CFG_HEARTBEAT, beat_ms);
        write_reg(CFG_REPEAT, repeats);
    endtask

    // Mostly steady time and held buttons with bounce, plus jumps and noise.
    task automatic run_random_scans(input int n_scans);
        t_scan_row row;
        int        pick;
        for (int n = 0; n < n_scans; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                stim_now = $urandom;
            else if (pick < 8)
                stim_now = stim_now + $urandom_range(0, 70000);
            else
                stim_now = stim_now + $urandom_range(0, 25);
            if ($urandom_range(0, 9) == 0)
                stim_held = stim_held ^ (5'd1 << $urandom_range(0, REPORT_BUTTONS - 1));
            if ($urandom_range(0, 4) == 0)
                stim_count = stim_count + $urandom_range(0, 6) - 3;
            if ($urandom_range(0, 39) == 0)
                stim_count = $urandom;
            row     = '0;
            row.now = stim_now;
            row.raw = stim_held;
            row.cnt = stim_count;
            if ($urandom_range(0, 7) == 0)
                row.raw = stim_held ^ 5'($urandom);
            drive_scan(row);
        end
        end_scans();
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Report sink with random stalls and one long hold-off.
    initial begin : report_sink
        int      stall;
        logic    rx_burst;
        t_report want;
        rx_burst = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (reports_seen % 50 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 5);
            if (reports_seen == LONG_STALL_AT)
                stall = LONG_STALL;
            repeat (stall) begin
                @(negedge clk);
                rep_if.ready <= 1'b0;
            end
            @(negedge clk);
            rep_if.ready <= 1'b1;
            do @(posedge clk); while (!rep_if.valid);
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("report transaction with no scan pass outstanding");
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("send", 32'(want.send), 32'(rep_if.send));
                check_field("button_mask", 32'(want.mask), 32'(rep_if.button_mask));
                check_field("report_count", want.count, rep_if.report_count);
                check_field("sequence_res", want.seq, rep_if.sequence_res);
                check_field("uptime_ms", want.uptime, rep_if.uptime_ms);
                check_field("presses_0", want.presses[0], rep_if.presses_0);
                check_field("presses_1", want.presses[1], rep_if.presses_1);
                check_field("presses_2", want.presses[2], rep_if.presses_2);
                check_field("presses_3", want.presses[3], rep_if.presses_3);
                check_field("presses_4", want.presses[4], rep_if.presses_4);
            end
        end
    end

    // Abort when no transaction of any kind completes for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((scan_if.valid && scan_if.ready) || (rep_if.valid && rep_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : main_flow
        rst_n               = 1'b0;
        scan_if.valid       = 1'b0;
        scan_if.now_ms      = '0;
        scan_if.raw_buttons = '1;
        scan_if.enc_count   = '0;
        rep_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_DEBOUNCE;
        cfg_if.data         = '0;
        mismatches          = 0;
        reports_seen        = 0;
        scans_sent          = 0;
        tx_burst            = 1'b0;

        // Shadow state after reset.
        sched_cfg       = '{DEBOUNCE_RST, MIN_INTERVAL_RST, HEARTBEAT_RST, REPEAT_RST};
        debounced       = '1;
        prev_raw        = '1;
        edge_stamp      = '0;
        press_cnt       = '0;
        last_report_ms  = '0;
        last_beat_ms    = '0;
        sent_count      = '0;
        sent_mask       = '0;
        anything_sent   = 1'b0;
        repeats_pending = '0;
        seq_num         = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed passes under the reset defaults.
        for (int r = 0; r < DEFAULT_ROWS; r++)
            drive_scan(directed_rows[r]);
        end_scans();
        drain_reports();

        // Heartbeat and repeat count of zero; upper data bits must be dropped.
        apply_setting(16'd0, 16'd0, 16'd0, 16'hFFF0);
        for (int r = DEFAULT_ROWS; r < NUM_ROWS; r++)
            drive_scan(directed_rows[r]);
        end_scans();

        stim_now   = 32'd6000;
        stim_held  = '1;
        stim_count = '0;
        for (int ph = 0; ph < 5; ph++) begin
            drain_reports();
            case (ph)
                0: apply_setting(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                                 16'($urandom_range(1, 300)), 16'($urandom_range(0, 15)));
                1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15);
                2: apply_setting(16'd15, 16'd20, 16'd1000, 16'd3);
                3: apply_setting(16'($urandom_range(0, 30)), 16'($urandom_range(0, 60)),
                                 16'($urandom_range(0, 500)), 16'($urandom));
                default: apply_setting(16'd0, 16'd0, 16'd1, 16'd1);
            endcase
            run_random_scans(ph == 2 ? 300 : 240);
        end

        drain_reports();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bdrs_pkg.sv
hdl/bdrs_if.sv
hdl/bdrs_lane.sv
hdl/bdrs_sched.sv
hdl/button_debounce_report_scheduler_top.sv
hdl/bdrs_checker.sv
dv/testbench.sv
